/* src/lvm_pkg.sv */
// Shared constants and types for the look-at view matrix core.
// No dependencies; imported by lvm_norm and lookat_view_matrix_core.
package lvm_pkg;

    // Default fraction bits of the Q-format on all ports.
    localparam int LVM_FRAC_BITS = 16;

    // Magnitudes are aligned so the largest lies in [2^(N-1), 2^N) before the square root.
    localparam int LVM_NORM_BITS = 30;

    // Matrix row carried by an output beat.
    typedef enum logic [1:0] {
        ROW_U    = 2'd0,
        ROW_V    = 2'd1,
        ROW_N    = 2'd2,
        ROW_LAST = 2'd3
    } t_row;

endpackage

/* src/lookat_view_matrix_core.sv */
// Look-at view matrix core: difference, three normalisers, cross products, translation.
// Depends on lvm_pkg and lvm_norm.
//
// One input beat carries eye, target and up in signed Q(32-FRAC_BITS).FRAC_BITS and yields
// four output beats, rows u, v, n and 0,0,0,1 in that order, tlast on the fourth, tuser set on
// all four when a vector had zero length (rows 0 to 2 then read as zero). The datapath is a
// single pipeline of 10 + 3 * (FRAC_BITS + 40) stages; a bit-per-stage square root and divider
// in each normaliser set that depth.
// A new item can enter every cycle unless stalled; the output port moves at most one row per
// cycle, so sustained throughput is one item per four rows. The input stays ready while rows
// are being sent and the pipeline only stalls once a finished item waits behind the one being sent.
module lookat_view_matrix_core
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = LVM_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [287:0] i_s_tdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // row_index, col0, col1, col2, col3, zero fill
    output logic [135:0] o_m_tdata,
    // degenerate
    output logic         o_m_tuser,
    output logic         o_m_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready
);

    localparam int NW  = FRAC_BITS + 2;
    localparam int DW1 = 33;
    localparam int PB  = 32 + NW;
    localparam int DW2 = PB + 1;
    localparam int PD  = 2 * NW;
    localparam int DW3 = PD + 1;
    localparam int PF  = NW + 32;
    localparam int GW  = PF + 2;
    localparam int SD1 = 192;
    localparam int SD2 = 96 + 3*NW + 1;
    localparam int SD3 = 96 + 6*NW + 1;

    logic en;

    // stage A: eye - target
    logic              r_a_vld;
    logic [3*DW1-1:0]  r_a_d;
    logic [SD1-1:0]    r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (en)  r_a_vld <= i_s_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_a_d[DW1*c +: DW1] <= DW1'($signed(i_s_tdata[32*c +: 32]))
                                     - DW1'($signed(i_s_tdata[96 + 32*c +: 32]));
            end
            r_a_side <= {i_s_tdata[287:192], i_s_tdata[95:0]};
        end
    end

    // n = normalise(eye - target)
    logic            n1_vld, n1_ok;
    logic [3*NW-1:0] n1_vec;
    logic [SD1-1:0]  n1_side;

    lvm_norm #(.IN_W(DW1), .SIDE_W(SD1), .FRAC_BITS(FRAC_BITS)) u_norm_n (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_a_vld), .i_vec(r_a_d), .i_side(r_a_side),
        .o_valid(n1_vld), .o_vec(n1_vec), .o_ok(n1_ok), .o_side(n1_side)
    );

    // stage B/C: up x n
    logic              r_b_vld, r_c_vld;
    logic signed [PB-1:0] r_b_p [6];
    logic [SD2-1:0]    r_b_side, r_c_side;
    logic [3*DW2-1:0]  r_c_t;
    logic signed [NW-1:0] bn [3];
    logic signed [31:0]   bu [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            bn[c] = $signed(n1_vec[NW*c +: NW]);
            bu[c] = $signed(n1_side[96 + 32*c +: 32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= n1_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_p[0] <= PB'(bu[1]) * PB'(bn[2]);
            r_b_p[1] <= PB'(bu[2]) * PB'(bn[1]);
            r_b_p[2] <= PB'(bu[2]) * PB'(bn[0]);
            r_b_p[3] <= PB'(bu[0]) * PB'(bn[2]);
            r_b_p[4] <= PB'(bu[0]) * PB'(bn[1]);
            r_b_p[5] <= PB'(bu[1]) * PB'(bn[0]);
            r_b_side <= {n1_ok, n1_vec, n1_side[95:0]};
            for (int c = 0; c < 3; c++) begin
                r_c_t[DW2*c +: DW2] <= DW2'(r_b_p[2*c]) - DW2'(r_b_p[2*c+1]);
            end
            r_c_side <= r_b_side;
        end
    end

    // u = normalise(up x n)
    logic            n2_vld, n2_ok;
    logic [3*NW-1:0] n2_vec;
    logic [SD2-1:0]  n2_side;

    lvm_norm #(.IN_W(DW2), .SIDE_W(SD2), .FRAC_BITS(FRAC_BITS)) u_norm_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_c_vld), .i_vec(r_c_t), .i_side(r_c_side),
        .o_valid(n2_vld), .o_vec(n2_vec), .o_ok(n2_ok), .o_side(n2_side)
    );

    // stage D/E: n x u
    logic              r_d_vld, r_e_vld;
    logic signed [PD-1:0] r_d_p [6];
    logic [SD3-1:0]    r_d_side, r_e_side;
    logic [3*DW3-1:0]  r_e_t;
    logic signed [NW-1:0] dn [3];
    logic signed [NW-1:0] du [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dn[c] = $signed(n2_side[96 + NW*c +: NW]);
            du[c] = $signed(n2_vec[NW*c +: NW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= n2_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_p[0] <= PD'(dn[1]) * PD'(du[2]);
            r_d_p[1] <= PD'(dn[2]) * PD'(du[1]);
            r_d_p[2] <= PD'(dn[2]) * PD'(du[0]);
            r_d_p[3] <= PD'(dn[0]) * PD'(du[2]);
            r_d_p[4] <= PD'(dn[0]) * PD'(du[1]);
            r_d_p[5] <= PD'(dn[1]) * PD'(du[0]);
            r_d_side <= {n2_ok & n2_side[96 + 3*NW], n2_vec, n2_side[96 + 3*NW - 1:0]};
            for (int c = 0; c < 3; c++) begin
                r_e_t[DW3*c +: DW3] <= DW3'(r_d_p[2*c]) - DW3'(r_d_p[2*c+1]);
            end
            r_e_side <= r_d_side;
        end
    end

    // v = normalise(n x u)
    logic            n3_vld, n3_ok;
    logic [3*NW-1:0] n3_vec;
    logic [SD3-1:0]  n3_side;

    lvm_norm #(.IN_W(DW3), .SIDE_W(SD3), .FRAC_BITS(FRAC_BITS)) u_norm_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_e_vld), .i_vec(r_e_t), .i_side(r_e_side),
        .o_valid(n3_vld), .o_vec(n3_vec), .o_ok(n3_ok), .o_side(n3_side)
    );

    // stage F..I: translation -dot(row, eye), rows packed u, v, n
    logic [9*NW-1:0]  f_rows;
    logic signed [31:0] f_eye [3];
    logic              r_f_vld, r_g_vld, r_h_vld, r_i_vld;
    logic signed [PF-1:0] r_f_p [3][3];
    logic signed [GW-1:0] r_g_sum [3];
    logic [GW-1:0]     r_h_mag [3];
    logic [2:0]        r_h_neg;
    logic [GW:0]       i_rq [3];
    logic [31:0]       n_i_t [3];
    logic [31:0]       r_i_t [3];
    logic [9*NW-1:0]   r_f_rows, r_g_rows, r_h_rows, r_i_rows;
    logic              r_f_ok, r_g_ok, r_h_ok, r_i_ok;

    assign f_rows = {n3_side[96 +: 3*NW], n3_vec, n3_side[96 + 3*NW +: 3*NW]};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            f_eye[c] = $signed(n3_side[32*c +: 32]);
        end
        for (int r = 0; r < 3; r++) begin
            i_rq[r] = ((GW+1)'(r_h_mag[r]) + ((GW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
            if (r_h_neg[r]) begin
                if (i_rq[r] > (GW+1)'(64'h8000_0000)) n_i_t[r] = 32'h8000_0000;
                else                                   n_i_t[r] = ~i_rq[r][31:0] + 1'b1;
            end else begin
                if (i_rq[r] > (GW+1)'(64'h7FFF_FFFF)) n_i_t[r] = 32'h7FFF_FFFF;
                else                                   n_i_t[r] = i_rq[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= n3_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_f_p[r][c] <= PF'($signed(f_rows[NW*(3*r + c) +: NW])) * PF'(f_eye[c]);
                end
                r_g_sum[r] <= GW'(r_f_p[r][0]) + GW'(r_f_p[r][1]) + GW'(r_f_p[r][2]);
                // the result is the negated sum: negative when the sum is positive
                r_h_neg[r] <= r_g_sum[r] > 0;
                r_h_mag[r] <= r_g_sum[r][GW-1] ? GW'(~r_g_sum[r] + 1'b1) : r_g_sum[r];
                r_i_t[r]   <= n_i_t[r];
            end
            r_f_rows <= f_rows;
            r_g_rows <= r_f_rows;
            r_h_rows <= r_g_rows;
            r_i_rows <= r_h_rows;
            r_f_ok   <= n3_ok & n3_side[96 + 6*NW];
            r_g_ok   <= r_f_ok;
            r_h_ok   <= r_g_ok;
            r_i_ok   <= r_h_ok;
        end
    end

    // output: one item held, sent as four row beats
    logic            r_s_vld;
    t_row            r_row;
    logic [9*NW-1:0] r_s_rows;
    logic [31:0]     r_s_t [3];
    logic            r_s_ok;
    logic            out_fire, ser_free;

    assign out_fire = r_s_vld && i_m_tready;
    assign ser_free = !r_s_vld || (out_fire && r_row == ROW_LAST);
    assign en       = ser_free || !r_i_vld;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_row   <= ROW_U;
        end else if (r_i_vld && ser_free) begin
            r_s_vld <= 1'b1;
            r_row   <= ROW_U;
        end else if (out_fire && r_row == ROW_LAST) begin
            r_s_vld <= 1'b0;
        end else if (out_fire) begin
            r_row   <= t_row'(r_row + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_i_vld && ser_free) begin
            r_s_rows <= r_i_rows;
            r_s_t    <= r_i_t;
            r_s_ok   <= r_i_ok;
        end
    end

    logic [31:0] col [4];

    always_comb begin
        for (int c = 0; c < 4; c++) col[c] = '0;
        case (r_row)
            ROW_U, ROW_V, ROW_N: begin
                if (r_s_ok) begin
                    for (int c = 0; c < 3; c++) begin
                        col[c] = 32'($signed(r_s_rows[NW*(3*32'(r_row) + c) +: NW]));
                    end
                    col[3] = r_s_t[r_row];
                end
            end
            ROW_LAST: col[3] = 32'(1) << FRAC_BITS;
            default: ;
        endcase
    end

    assign o_m_tdata  = {6'b0, col[3], col[2], col[1], col[0], r_row};
    assign o_m_tuser  = !r_s_ok;
    assign o_m_tlast  = r_row == ROW_LAST;
    assign o_m_tvalid = r_s_vld;

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_row != ROW_LAST && !(r_i_vld && ser_free)
        |=> r_row == t_row'(2'($past(r_row)) + 2'd1))
        else $error("row counter skipped a row");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_row == ROW_LAST && !r_i_vld |=> !o_m_tvalid)
        else $error("item repeated after last row");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s_vld |-> o_s_tready)
        else $error("input stalled with empty output stage");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && r_row != ROW_LAST |-> o_m_tdata[129:2] == '0)
        else $error("degenerate row carries non-zero entries");

    a_load_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i_vld && ser_free |=> r_row == ROW_U && o_m_tvalid)
        else $error("new item does not start at row 0");

endmodule

/* src/lvm_norm.sv */
// Pipelined 3-vector normaliser: magnitude alignment, square root, three dividers.
// Depends on lvm_pkg; instantiated three times by lookat_view_matrix_core.
module lvm_norm
    import lvm_pkg::*;
#(
    parameter int IN_W      = 33,
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = LVM_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [3*IN_W-1:0]           i_vec,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [3*(FRAC_BITS+2)-1:0]  o_vec,
    output logic                        o_ok,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int NW   = FRAC_BITS + 2;
    localparam int QW   = FRAC_BITS + 1;
    localparam int SW   = LVM_NORM_BITS;
    localparam int RS   = SW + 1;
    localparam int RW   = 2 * SW + 4;
    localparam int GRP  = (IN_W + 7) / 8;
    localparam int PW   = $clog2(IN_W);
    localparam int NUMW = SW + 1 + FRAC_BITS;
    localparam int DW   = NUMW + 1;
    localparam int LAT  = 6 + RS + 1 + QW + 1;

    // valid and sideband travel alongside the datapath
    logic [LAT-1:0]    r_vld;
    logic [SIDE_W-1:0] r_side [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_side  = r_side[LAT-1];

    // stage 1: magnitudes
    logic [IN_W-1:0] n1_a [3];
    logic [IN_W-1:0] r1_a [3];
    logic [2:0]      r1_sg;

    always_comb begin
        logic [IN_W-1:0] x;
        x = '0;
        for (int c = 0; c < 3; c++) begin
            x = i_vec[IN_W*c +: IN_W];
            n1_a[c] = x[IN_W-1] ? IN_W'(~x + 1'b1) : x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r1_a[c]  <= n1_a[c];
                r1_sg[c] <= i_vec[IN_W*c + IN_W-1];
            end
        end
    end

    // stage 2: leading one per byte
    logic [8*GRP-1:0] orv;
    logic [GRP-1:0]   n2_gnz;
    logic [2:0]       n2_gidx [GRP];
    logic [GRP-1:0]   r2_gnz;
    logic [2:0]       r2_gidx [GRP];
    logic [IN_W-1:0]  r2_a [3];
    logic [2:0]       r2_sg;

    always_comb begin
        orv = (8*GRP)'(r1_a[0] | r1_a[1] | r1_a[2]);
        for (int g = 0; g < GRP; g++) begin
            n2_gnz[g]  = |orv[8*g +: 8];
            n2_gidx[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (orv[8*g + b]) n2_gidx[g] = 3'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_gnz  <= n2_gnz;
            r2_gidx <= n2_gidx;
            r2_a    <= r1_a;
            r2_sg   <= r1_sg;
        end
    end

    // stage 3: top set bit over the bytes
    logic [PW-1:0]   n3_p;
    logic            n3_zero;
    logic [PW-1:0]   r3_p;
    logic            r3_zero;
    logic [IN_W-1:0] r3_a [3];
    logic [2:0]      r3_sg;

    always_comb begin
        n3_p    = '0;
        n3_zero = 1'b1;
        for (int g = 0; g < GRP; g++) begin
            if (r2_gnz[g]) begin
                n3_p    = PW'(8*g) + PW'(r2_gidx[g]);
                n3_zero = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p    <= n3_p;
            r3_zero <= n3_zero;
            r3_a    <= r2_a;
            r3_sg   <= r2_sg;
        end
    end

    // stage 4: align so the top bit sits at SW-1; right shifts truncate
    logic [IN_W+SW-2:0] ext [3];
    logic [SW-1:0]      r4_a [3];
    logic [2:0]         r4_sg;
    logic               r4_zero;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ext[c] = {r3_a[c], {(SW-1){1'b0}}} >> r3_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r4_a[c] <= ext[c][SW-1:0];
            end
            r4_sg   <= r3_sg;
            r4_zero <= r3_zero;
        end
    end

    // stage 5: squares
    logic [2*SW-1:0] r5_sq [3];
    logic [SW-1:0]   r5_a [3];
    logic [2:0]      r5_sg;
    logic            r5_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r5_sq[c] <= (2*SW)'(r4_a[c]) * (2*SW)'(r4_a[c]);
            end
            r5_a    <= r4_a;
            r5_sg   <= r4_sg;
            r5_zero <= r4_zero;
        end
    end

    // stage 6 and the square root, one result bit per stage
    logic [RW-1:0] q_rem  [RS+1];
    logic [RW-1:0] q_root [RS+1];
    logic [SW-1:0] q_a    [RS+1][3];
    logic [2:0]    q_sg   [RS+1];
    logic          q_zero [RS+1];
    logic [RW-1:0] q_bit  [RS];
    logic [RW-1:0] q_try  [RS];

    always_comb begin
        for (int k = 0; k < RS; k++) begin
            q_bit[k] = RW'(1) << (2*(RS-1-k));
            q_try[k] = q_root[k] + q_bit[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            q_rem[0]  <= RW'(r5_sq[0]) + RW'(r5_sq[1]) + RW'(r5_sq[2]);
            q_root[0] <= '0;
            q_a[0]    <= r5_a;
            q_sg[0]   <= r5_sg;
            q_zero[0] <= r5_zero;
            for (int k = 0; k < RS; k++) begin
                if (q_rem[k] >= q_try[k]) begin
                    q_rem[k+1]  <= q_rem[k] - q_try[k];
                    q_root[k+1] <= (q_root[k] >> 1) + q_bit[k];
                end else begin
                    q_rem[k+1]  <= q_rem[k];
                    q_root[k+1] <= q_root[k] >> 1;
                end
                q_a[k+1]    <= q_a[k];
                q_sg[k+1]   <= q_sg[k];
                q_zero[k+1] <= q_zero[k];
            end
        end
    end

    // dividers: round(a * 2^F / len), one quotient bit per stage, three lanes
    logic [DW-1:0] dv_rem  [QW+1][3];
    logic [QW-1:0] dv_q    [QW+1][3];
    logic [SW:0]   dv_den  [QW+1];
    logic [2:0]    dv_sg   [QW+1];
    logic          dv_zero [QW+1];
    logic [DW-1:0] dv_try  [QW];
    logic [SW:0]   len;

    assign len = q_root[RS][SW:0];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            dv_try[k] = DW'(dv_den[k]) << (QW-1-k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                dv_rem[0][c] <= DW'({q_a[RS][c], {FRAC_BITS{1'b0}}}) + DW'(len >> 1);
                dv_q[0][c]   <= '0;
            end
            dv_den[0]  <= len;
            dv_sg[0]   <= q_sg[RS];
            dv_zero[0] <= q_zero[RS];
            for (int k = 0; k < QW; k++) begin
                for (int c = 0; c < 3; c++) begin
                    if (dv_rem[k][c] >= dv_try[k]) begin
                        dv_rem[k+1][c] <= dv_rem[k][c] - dv_try[k];
                        dv_q[k+1][c]   <= dv_q[k][c] | (QW'(1) << (QW-1-k));
                    end else begin
                        dv_rem[k+1][c] <= dv_rem[k][c];
                        dv_q[k+1][c]   <= dv_q[k][c];
                    end
                end
                dv_den[k+1]  <= dv_den[k];
                dv_sg[k+1]   <= dv_sg[k];
                dv_zero[k+1] <= dv_zero[k];
            end
        end
    end

    // final stage: apply signs, zero vector reads as all zero
    logic [3*NW-1:0] n_out;
    logic [3*NW-1:0] r_out;
    logic            r_ok;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (dv_zero[QW])
                n_out[NW*c +: NW] = '0;
            else if (dv_sg[QW][c])
                n_out[NW*c +: NW] = NW'(~NW'(dv_q[QW][c]) + 1'b1);
            else
                n_out[NW*c +: NW] = NW'(dv_q[QW][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
            r_ok  <= !dv_zero[QW];
        end
    end

    assign o_vec = r_out;
    assign o_ok  = r_ok;

endmodule
